>>> hw/rtl/ult_pkg.sv
// Package for the unsorted list table: sizes, command codes and the
// request and response payload types. No dependencies.
package ult_pkg;

   localparam int CAPACITY    = 32;
   localparam int ITEM_WIDTH  = 16;
   localparam int ADDR_WIDTH  = $clog2(CAPACITY);
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   localparam logic [2:0] CMD_EMPTY    = 3'd0;
   localparam logic [2:0] CMD_PUT      = 3'd1;
   localparam logic [2:0] CMD_GET      = 3'd2;
   localparam logic [2:0] CMD_DELETE   = 3'd3;
   localparam logic [2:0] CMD_SHIFT    = 3'd4;
   localparam logic [2:0] CMD_RESET_IT = 3'd5;
   localparam logic [2:0] CMD_NEXT     = 3'd6;

   typedef struct packed {
      logic [2:0]            command;
      logic [ITEM_WIDTH-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [ITEM_WIDTH-1:0]  item_out;
      logic                   found;
      logic [COUNT_WIDTH-1:0] count;
      logic                   is_full;
      logic                   error;
   } rsp_type;

endpackage

>>> hw/rtl/ult_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module ult_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/unsorted_list_table.sv
// Unsorted list table: entries in one RAM, walked one read per cycle.
// Empty, put, reset-iterator, next-past-end, the unused command, and get, delete or shift
// right with nothing to walk go straight to the output stage; next reads one entry; get
// and delete walk the list (a get hit ends early); shift right walks it, then moves the
// old last entry to the front. One command at a time; a new command is taken once the
// previous result is in the output register. Synchronous reset clears count and iterator.
module unsorted_list_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ult_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ult_pkg::rsp_type rsp_data
);
   import ult_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] CAP_COUNT = COUNT_WIDTH'(CAPACITY);
   localparam logic [COUNT_WIDTH-1:0] ONE       = COUNT_WIDTH'(1);

   logic [1:0]             state_ff, state_in;
   logic [2:0]             cmd_ff, cmd_in;
   logic [ITEM_WIDTH-1:0]  key_ff, key_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] rpos_ff, rpos_in;
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic [COUNT_WIDTH-1:0] keep_ff, keep_in;
   logic                   issue_ff, issue_in;
   logic                   dvld_ff;
   logic [ADDR_WIDTH-1:0]  didx_ff;
   logic [ITEM_WIDTH-1:0]  last_ff, last_in;
   logic [ITEM_WIDTH-1:0]  res_item_ff, res_item_in;
   logic                   res_found_ff, res_found_in;
   logic                   res_error_ff, res_error_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_xfer;
   logic                   out_free;
   logic                   rd_en;
   logic [ADDR_WIDTH-1:0]  rd_addr;
   logic [ITEM_WIDTH-1:0]  rd_data;
   logic                   wr_en;
   logic [ADDR_WIDTH-1:0]  wr_addr;
   logic [ITEM_WIDTH-1:0]  wr_data;
   logic                   last_data;

   ult_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_en     = (state_ff == ST_RUN) && issue_ff;
   assign rd_addr   = idx_ff[ADDR_WIDTH-1:0];
   // final read data of a walk is handled in the same cycle the walk ends
   assign last_data = dvld_ff && !issue_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rpos_in      = rpos_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      issue_in     = issue_ff;
      last_in      = last_ff;
      res_item_in  = res_item_ff;
      res_found_in = res_found_ff;
      res_error_in = res_error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in       = req_data.command;
               key_in       = req_data.item_value;
               res_item_in  = '0;
               res_found_in = 1'b0;
               res_error_in = 1'b0;
               keep_in      = '0;
               state_in     = ST_DONE;
               case (req_data.command)
                  CMD_EMPTY: begin
                     count_in = '0;
                  end
                  CMD_PUT: begin
                     if (count_ff == CAP_COUNT) begin
                        res_error_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_WIDTH-1:0];
                        wr_data  = req_data.item_value;
                        count_in = count_ff + ONE;
                     end
                  end
                  CMD_GET: begin
                     res_item_in = req_data.item_value;
                     idx_in      = '0;
                     issue_in    = 1'b1;
                     if (count_ff != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  CMD_DELETE: begin
                     idx_in   = '0;
                     issue_in = 1'b1;
                     if (count_ff != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  CMD_SHIFT: begin
                     idx_in   = count_ff - ONE;
                     issue_in = 1'b1;
                     if (count_ff > ONE) begin
                        state_in = ST_RUN;
                     end
                  end
                  CMD_RESET_IT: begin
                     rpos_in = '0;
                  end
                  CMD_NEXT: begin
                     idx_in   = rpos_ff;
                     issue_in = 1'b1;
                     if (rpos_ff < count_ff) begin
                        state_in = ST_RUN;
                     end else begin
                        res_error_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_RUN: begin
            // read issue side
            if (issue_ff) begin
               case (cmd_ff) inside
                  CMD_GET, CMD_DELETE: begin
                     idx_in   = idx_ff + ONE;
                     issue_in = (idx_ff + ONE) < count_ff;
                  end
                  CMD_SHIFT: begin
                     idx_in   = idx_ff - ONE;
                     issue_in = (idx_ff != '0);
                  end
                  default: begin
                     issue_in = 1'b0;
                  end
               endcase
            end
            // read data side
            case (cmd_ff)
               CMD_GET: begin
                  if (dvld_ff && rd_data == key_ff) begin
                     res_found_in = 1'b1;
                     res_item_in  = rd_data;
                     issue_in     = 1'b0;
                     state_in     = ST_DONE;
                  end else if (last_data) begin
                     state_in = ST_DONE;
                  end
               end
               CMD_DELETE: begin
                  if (dvld_ff && rd_data != key_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = keep_ff[ADDR_WIDTH-1:0];
                     wr_data = rd_data;
                     keep_in = keep_ff + ONE;
                  end
                  if (last_data) begin
                     count_in = keep_in;
                     state_in = ST_DONE;
                  end
               end
               CMD_SHIFT: begin
                  if (dvld_ff) begin
                     if (COUNT_WIDTH'(didx_ff) == count_ff - ONE) begin
                        last_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = didx_ff + ADDR_WIDTH'(1);
                        wr_data = rd_data;
                     end
                  end
                  if (last_data) begin
                     state_in = ST_FIX;
                  end
               end
               default: begin
                  if (dvld_ff) begin
                     res_item_in = rd_data;
                     rpos_in     = rpos_ff + ONE;
                     state_in    = ST_DONE;
                  end
               end
            endcase
         end

         ST_FIX: begin
            // old last entry lands at the front
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = last_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.item_out  = res_item_ff;
               rsp_in.found     = res_found_ff;
               rsp_in.count     = count_ff;
               rsp_in.is_full   = (count_ff == CAP_COUNT);
               rsp_in.error     = res_error_ff;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rpos_ff      <= '0;
         issue_ff     <= 1'b0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rpos_ff      <= rpos_in;
         issue_ff     <= issue_in;
         dvld_ff      <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      keep_ff      <= keep_in;
      didx_ff      <= rd_addr;
      last_ff      <= last_in;
      res_item_ff  <= res_item_in;
      res_found_ff <= res_found_in;
      res_error_ff <= res_error_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> bench/unsorted_list_table_test.sv
// Testbench for unsorted_list_table: drives list commands with random gaps and
// stalls, predicts every response and checks them in order.
// Depends on ult_pkg and unsorted_list_table.
`timescale 1ns / 1ps

module unsorted_list_table_test;
   import ult_pkg::*;

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam int         RANDOM_ITEMS = 1450;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         TAIL_CYCLES  = 64;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   unsorted_list_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Shadow copy of the list contents
   logic [ITEM_WIDTH-1:0]  list_mem [CAPACITY];
   logic [COUNT_WIDTH-1:0] list_count = '0;
   logic [COUNT_WIDTH-1:0] iter_pos   = '0;

   req_type command_q [$];
   rsp_type response_q [$];
   logic [ITEM_WIDTH-1:0] value_pool [6];

   int  total_items    = 0;
   int  issued_count   = 0;
   int  accepted_count = 0;
   int  mismatches     = 0;
   int  cycle_count    = 0;
   int  idle_left      = 0;
   int  stall_left     = 0;
   bit  send_calm      = 1'b0;
   bit  sink_calm      = 1'b0;
   rsp_type predicted;
   rsp_type oldest;

   task automatic apply_list_command(input req_type cmd, output rsp_type res);
      int i;
      int keep;
      logic [ITEM_WIDTH-1:0] last;
      res = '0;
      case (cmd.command)
         CMD_EMPTY: begin
            list_count = '0;
         end
         CMD_PUT: begin
            if (list_count >= CAPACITY) begin
               res.error = 1'b1;
            end else begin
               list_mem[list_count[ADDR_WIDTH-1:0]] = cmd.item_value;
               list_count++;
            end
         end
         CMD_GET: begin
            res.item_out = cmd.item_value;
            for (i = 0; i < list_count; i++) begin
               if (list_mem[ADDR_WIDTH'(i)] == cmd.item_value) begin
                  res.found    = 1'b1;
                  res.item_out = list_mem[ADDR_WIDTH'(i)];
                  break;
               end
            end
         end
         CMD_DELETE: begin
            keep = 0;
            for (i = 0; i < list_count; i++) begin
               if (list_mem[ADDR_WIDTH'(i)] != cmd.item_value) begin
                  list_mem[ADDR_WIDTH'(keep)] = list_mem[ADDR_WIDTH'(i)];
                  keep++;
               end
            end
            list_count = COUNT_WIDTH'(keep);
         end
         CMD_SHIFT: begin
            if (list_count > 1) begin
               last = list_mem[ADDR_WIDTH'(list_count - 1'b1)];
               for (i = int'(list_count) - 1; i > 0; i--) begin
                  list_mem[ADDR_WIDTH'(i)] = list_mem[ADDR_WIDTH'(i - 1)];
               end
               list_mem[0] = last;
            end
         end
         CMD_RESET_IT: begin
            iter_pos = '0;
         end
         CMD_NEXT: begin
            if (iter_pos < list_count) begin
               res.item_out = list_mem[iter_pos[ADDR_WIDTH-1:0]];
               iter_pos++;
            end else begin
               res.error = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.count   = list_count;
      res.is_full = (list_count == CAPACITY);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic queue_command(input logic [2:0] c, input logic [ITEM_WIDTH-1:0] v);
      req_type r;
      r.command    = c;
      r.item_value = v;
      command_q.push_back(r);
   endtask

   // Mostly values from a small pool, so gets hit and deletes remove duplicates
   function automatic logic [ITEM_WIDTH-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) begin
         return value_pool[3'($urandom_range(0, 5))];
      end
      return ITEM_WIDTH'($urandom_range(0, 65535));
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Request driver: a new transfer is presented once the previous one is taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_count == issued_count) begin
            if (idle_left > 0) begin
               req_valid <= 1'b0;
               idle_left--;
            end else if (command_q.size() > 0) begin
               req_data  <= command_q.pop_front();
               req_valid <= 1'b1;
               issued_count++;
               if ($urandom_range(0, 49) == 0) begin
                  send_calm = !send_calm;
               end
               idle_left = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = pick_gap(1'b0);
         end else begin
            rsp_ready <= 1'b1;
         end
         if ($urandom_range(0, 299) == 0) begin
            sink_calm = !sink_calm;
         end
      end
   end

   // Monitor: the response is checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (response_q.size() == 0) begin
               report_mismatch("response transfer with nothing outstanding");
            end else begin
               oldest = response_q.pop_front();
               check_field("item_out", 32'(rsp_data.item_out), 32'(oldest.item_out));
               check_field("found", 32'(rsp_data.found), 32'(oldest.found));
               check_field("count", 32'(rsp_data.count), 32'(oldest.count));
               check_field("is_full", 32'(rsp_data.is_full), 32'(oldest.is_full));
               check_field("error", 32'(rsp_data.error), 32'(oldest.error));
            end
         end
         if (req_valid && req_ready) begin
            apply_list_command(req_data, predicted);
            response_q.push_back(predicted);
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("unsorted_list_table_test failed");
         $finish;
      end
   end

   initial begin
      int pick;
      int n;
      int est_count;
      int random_goal;

      value_pool[0] = 16'h0000;
      value_pool[1] = 16'hFFFF;
      for (n = 2; n < 6; n++) begin
         value_pool[3'(n)] = ITEM_WIDTH'($urandom_range(0, 65535));
      end

      // Directed: operations on an empty list, extremes, duplicates, iterator overrun
      queue_command(CMD_NEXT, 16'h0000);
      queue_command(CMD_GET, 16'h0001);
      queue_command(CMD_SHIFT, 16'h0000);
      queue_command(CMD_DELETE, 16'h0000);
      queue_command(CMD_UNUSED, 16'hFFFF);
      queue_command(CMD_PUT, 16'h0000);
      queue_command(CMD_PUT, 16'hFFFF);
      queue_command(CMD_PUT, 16'h8001);
      queue_command(CMD_PUT, 16'hFFFF);
      queue_command(CMD_GET, 16'hFFFF);
      queue_command(CMD_GET, 16'h1234);
      queue_command(CMD_SHIFT, 16'h0000);
      queue_command(CMD_RESET_IT, 16'h0000);
      repeat (4) queue_command(CMD_NEXT, 16'h0000);
      queue_command(CMD_NEXT, 16'hFFFF);
      queue_command(CMD_DELETE, 16'hFFFF);
      queue_command(CMD_DELETE, 16'h5555);
      queue_command(CMD_NEXT, 16'h0000);
      queue_command(CMD_EMPTY, 16'hFFFF);
      queue_command(CMD_PUT, 16'h7FFF);
      queue_command(CMD_SHIFT, 16'h0000);
      queue_command(CMD_GET, 16'h7FFF);

      // Random: mostly well-formed sequences, est_count only steers their length
      est_count   = 1;
      random_goal = command_q.size() + RANDOM_ITEMS;
      while (command_q.size() < random_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            n = (pick < 5) ? 34 : $urandom_range(1, 12);
            repeat (n) queue_command(CMD_PUT, pick_value());
            est_count = (est_count + n > CAPACITY) ? CAPACITY : est_count + n;
         end else if (pick < 40) begin
            queue_command(CMD_RESET_IT, pick_value());
            repeat ($urandom_range(0, est_count + 2)) queue_command(CMD_NEXT, pick_value());
         end else if (pick < 55) begin
            repeat ($urandom_range(1, 4)) queue_command(CMD_GET, pick_value());
         end else if (pick < 63) begin
            queue_command(CMD_DELETE, pick_value());
         end else if (pick < 71) begin
            repeat ($urandom_range(1, 3)) queue_command(CMD_SHIFT, pick_value());
            repeat ($urandom_range(0, 3)) queue_command(CMD_NEXT, pick_value());
         end else if (pick < 74) begin
            queue_command(CMD_EMPTY, pick_value());
            est_count = 0;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               queue_command(3'($urandom_range(1, 7)), ITEM_WIDTH'($urandom_range(0, 65535)));
            end
         end
      end
      total_items = command_q.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items || response_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("unsorted_list_table_test passed");
      end else begin
         $display("unsorted_list_table_test failed");
      end
      $finish;
   end

endmodule
